// ===== rtl/core/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants of the line printer column formatter.
// ----------------------------------------------------------------------------
package lpc_pkg;

	localparam int unsigned TAB_WIDTH_DEF = 8;
	localparam logic [15:0] COLUMN_LIMIT_RST = 16'd132;

	localparam logic [6:0] CH_CR    = 7'h0D;
	localparam logic [6:0] CH_LF    = 7'h0A;
	localparam logic [6:0] CH_FF    = 7'h0C;
	localparam logic [6:0] CH_TAB   = 7'h09;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_QMARK = 7'h3F;

	localparam int unsigned IOT_SKIP  = 0;
	localparam int unsigned IOT_CLEAR = 1;
	localparam int unsigned IOT_PRINT = 2;

	typedef struct packed {
		logic [2:0]  iot_bits;
		logic [11:0] accumulator;
	} in_item_t;

	typedef struct packed {
		logic       skip_request;
		logic       char_valid;
		logic [6:0] char_code;
		logic       last;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_LINE,
		CMD_TAB,
		CMD_CHAR
	} cmd_kind_t;

	typedef struct packed {
		logic       skip;
		cmd_kind_t  kind;
		logic [6:0] code;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_TAB,
		BK_NEWLINE
	} back_state_t;

endpackage

// ===== rtl/core/line_printer_iot_column_formatter.sv =====
// ----------------------------------------------------------------------------
// line_printer_iot_column_formatter
// Line printer I/O instruction handler with column formatting.
// ----------------------------------------------------------------------------
// Usage: instructions enter through a queue-style port (push/full, one beat
// per instruction carrying iot_bits and accumulator). Results leave through
// a queue-style port (empty/pop); each beat carries skip_request, one
// character for the paper and last on the final beat of an instruction.
// The column limit is written on the cfg_valid/cfg_ready channel, which is
// always ready; write it only while the block is idle.
// The front answers skip and ready at acceptance and queues a command in a
// two-entry queue; the back end turns each command into results at one
// result per cycle while the receiver keeps popping, so an instruction gives
// one beat for a plain result, two for a character with an automatic newline
// and up to TAB_WIDTH for a tab, through the queue and the result register.
// Reset clears the column to 0, sets the printer ready flag and loads a
// column limit of 132. When the receiver stops popping, the result register
// holds its beat, the back end waits and the queue fills, then full rises.
// ----------------------------------------------------------------------------
module line_printer_iot_column_formatter import lpc_pkg::*; #(
	parameter int unsigned TAB_WIDTH = TAB_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    in_item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic accept;
	cmd_t front_cmd, back_cmd;
	logic cmd_avail, cmd_pop;

	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	lpc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_item),
		.cmd    (front_cmd)
	);

	lpc_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_cmd (front_cmd),
		.full   (full),
		.rd_en  (cmd_pop),
		.avail  (cmd_avail),
		.rd_cmd (back_cmd)
	);

	lpc_back #(
		.TAB_WIDTH (TAB_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd_avail (cmd_avail),
		.cmd       (back_cmd),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.out_item  (out_item)
	);

endmodule

// ===== rtl/core/lpc_front.sv =====
// ----------------------------------------------------------------------------
// lpc_front
// Accepts instructions, answers the skip test, keeps the ready flag and
// classifies the character into a command for the back end.
// ----------------------------------------------------------------------------
module lpc_front import lpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	output cmd_t     cmd
);

	logic       ready_q;
	logic [6:0] ch;

	assign ch = item.accumulator[6:0];

	always_comb begin
		cmd.skip = item.iot_bits[IOT_SKIP] & ready_q;
		cmd.kind = CMD_NONE;
		cmd.code = 7'd0;
		if (item.iot_bits[IOT_PRINT]) begin
			priority if (ch == CH_CR || ch == CH_LF || ch == CH_FF) begin
				cmd.kind = CMD_LINE;
				cmd.code = ch;
			end else if (ch == CH_TAB) begin
				cmd.kind = CMD_TAB;
				cmd.code = CH_SPACE;
			end else if (ch < CH_SPACE) begin
				cmd.kind = CMD_CHAR;
				cmd.code = CH_QMARK;
			end else begin
				cmd.kind = CMD_CHAR;
				cmd.code = ch;
			end
		end
	end

	// print sets ready after the clear, so print wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b1;
		end else if (accept) begin
			if (item.iot_bits[IOT_PRINT]) begin
				ready_q <= 1'b1;
			end else if (item.iot_bits[IOT_CLEAR]) begin
				ready_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/lpc_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lpc_cmd_fifo
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module lpc_cmd_fifo import lpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd_en,
	output logic avail,
	output cmd_t rd_cmd
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full   = (count_q == 2'd2);
	assign avail  = (count_q != 2'd0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/lpc_back.sv =====
// ----------------------------------------------------------------------------
// lpc_back
// Carries out print commands: tracks the column, expands tabs, forces the
// automatic newline and fills the result register.
// ----------------------------------------------------------------------------
module lpc_back import lpc_pkg::*; #(
	parameter int unsigned TAB_WIDTH = TAB_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        cmd_avail,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	input  logic        pop,
	output logic        empty,
	output out_item_t   out_item
);

	localparam int unsigned PW = $clog2(TAB_WIDTH);
	localparam int unsigned RW = $clog2(TAB_WIDTH + 1);

	back_state_t   state_q, state_d;
	logic [15:0]   col_q, col_d, col_inc;
	logic [PW-1:0] phase_q, phase_d, phase_inc;
	logic [RW-1:0] remain_q, remain_d, spaces;
	logic [15:0]   limit_q;
	out_item_t     out_q, out_d;
	logic          out_valid_q;
	logic          can_load, load, wrap;

	assign can_load = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign out_item = out_q;

	// phase is column mod tab width, kept in step with the column
	assign col_inc = col_q + 16'd1;
	always_comb begin
		if (col_inc == 16'd0 || phase_q == PW'(TAB_WIDTH - 1)) begin
			phase_inc = '0;
		end else begin
			phase_inc = phase_q + PW'(1);
		end
	end

	assign spaces = RW'(TAB_WIDTH) - RW'(phase_q);
	assign wrap   = (limit_q != 16'd0) && (col_inc >= limit_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_avail && can_load) begin
					if (cmd.kind == CMD_TAB && spaces != RW'(1)) begin
						state_d = BK_TAB;
					end else if (cmd.kind == CMD_CHAR && wrap) begin
						state_d = BK_NEWLINE;
					end
				end
			end
			BK_TAB: begin
				if (can_load && remain_q == RW'(1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_NEWLINE: begin
				if (can_load) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs and datapath
	always_comb begin
		cmd_pop  = 1'b0;
		load     = 1'b0;
		col_d    = col_q;
		phase_d  = phase_q;
		remain_d = remain_q;
		out_d    = out_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_avail && can_load) begin
					cmd_pop = 1'b1;
					load    = 1'b1;
					out_d.skip_request = cmd.skip;
					out_d.char_valid   = 1'b1;
					out_d.char_code    = cmd.code;
					out_d.last         = 1'b1;
					unique case (cmd.kind)
						CMD_NONE: begin
							out_d.char_valid = 1'b0;
							out_d.char_code  = 7'd0;
						end
						CMD_LINE: begin
							col_d   = 16'd0;
							phase_d = '0;
						end
						CMD_TAB: begin
							out_d.last = (spaces == RW'(1));
							col_d      = col_inc;
							phase_d    = phase_inc;
							remain_d   = spaces - RW'(1);
						end
						CMD_CHAR: begin
							out_d.last = !wrap;
							col_d      = col_inc;
							phase_d    = phase_inc;
						end
						default: ;
					endcase
				end
			end
			BK_TAB: begin
				if (can_load) begin
					load     = 1'b1;
					out_d    = '{skip_request: 1'b0, char_valid: 1'b1, char_code: CH_SPACE,
						last: (remain_q == RW'(1))};
					col_d    = col_inc;
					phase_d  = phase_inc;
					remain_d = remain_q - RW'(1);
				end
			end
			BK_NEWLINE: begin
				if (can_load) begin
					load    = 1'b1;
					out_d   = '{skip_request: 1'b0, char_valid: 1'b1, char_code: CH_LF,
						last: 1'b1};
					col_d   = 16'd0;
					phase_d = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			col_q       <= 16'd0;
			phase_q     <= '0;
			remain_q    <= '0;
			limit_q     <= COLUMN_LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			col_q    <= col_d;
			phase_q  <= phase_d;
			remain_q <= remain_d;
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= out_d;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line printer column formatter: directed and
// random instructions are pushed in, every result beat is predicted from a
// column/ready model kept here and compared field by field on pop.
// ----------------------------------------------------------------------------
module tb;
	import lpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TAB_W       = TAB_WIDTH_DEF;
	localparam int          STALL_LIMIT = 1000;
	localparam int          DRAIN_GAP   = 6;
	localparam int          MAX_GAP     = 18;

	localparam logic [2:0] OP_NONE  = 3'b000;
	localparam logic [2:0] OP_SKIP  = 3'(1 << IOT_SKIP);
	localparam logic [2:0] OP_CLEAR = 3'(1 << IOT_CLEAR);
	localparam logic [2:0] OP_PRINT = 3'(1 << IOT_PRINT);

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        full;
	in_item_t    in_item   = '0;
	logic        empty;
	logic        pop       = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;

	// printer model
	logic [15:0] paper_col;
	logic [15:0] col_limit;
	logic        printer_ready;
	out_item_t   expected_beats[$];

	int  mismatch_count = 0;
	int  idle_cycles    = 0;
	int  rx_wait        = 0;
	bit  tx_eager       = 1'b0;
	bit  rx_eager       = 1'b0;

	line_printer_iot_column_formatter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// queues the beats one instruction produces on the paper side
	function automatic void predict_printout(input in_item_t it);
		logic       skip_bit;
		logic [6:0] ch;
		logic [6:0] chars[$];
		int unsigned n_spaces;
		out_item_t  beat;
		skip_bit = it.iot_bits[IOT_SKIP] && printer_ready;
		if (it.iot_bits[IOT_CLEAR])
			printer_ready = 1'b0;
		if (!it.iot_bits[IOT_PRINT]) begin
			beat = '{skip_request: skip_bit, char_valid: 1'b0, char_code: '0, last: 1'b1};
			expected_beats.push_back(beat);
			return;
		end
		ch = it.accumulator[6:0];
		if (ch == CH_CR || ch == CH_LF || ch == CH_FF) begin
			chars.push_back(ch);
			paper_col = '0;
		end else if (ch == CH_TAB) begin
			n_spaces = TAB_W - (int'(paper_col) % TAB_W);
			repeat (n_spaces) chars.push_back(CH_SPACE);
			paper_col = 16'(paper_col + n_spaces);
		end else begin
			if (ch < CH_SPACE)
				ch = CH_QMARK;
			chars.push_back(ch);
			paper_col = 16'(paper_col + 1);
			if (col_limit != 0 && paper_col >= col_limit) begin
				chars.push_back(CH_LF);
				paper_col = '0;
			end
		end
		printer_ready = 1'b1;
		foreach (chars[i]) begin
			beat.skip_request = (i == 0) ? skip_bit : 1'b0;
			beat.char_valid   = 1'b1;
			beat.char_code    = chars[i];
			beat.last         = (i == chars.size() - 1);
			expected_beats.push_back(beat);
		end
	endfunction

	task automatic report_mismatch(input string what, input int unsigned exp_v,
			input int unsigned got_v);
		$display("[%0t] mismatch %s: expected %0h got %0h", $realtime, what, exp_v, got_v);
		mismatch_count++;
	endtask

	task automatic check_beat(input out_item_t got);
		out_item_t exp_b;
		if (expected_beats.size() == 0) begin
			report_mismatch("unexpected beat", 0, 32'(got));
			return;
		end
		exp_b = expected_beats.pop_front();
		if (got.skip_request !== exp_b.skip_request)
			report_mismatch("skip_request", 32'(exp_b.skip_request), 32'(got.skip_request));
		if (got.char_valid !== exp_b.char_valid)
			report_mismatch("char_valid", 32'(exp_b.char_valid), 32'(got.char_valid));
		if (got.char_code !== exp_b.char_code)
			report_mismatch("char_code", 32'(exp_b.char_code), 32'(got.char_code));
		if (got.last !== exp_b.last)
			report_mismatch("last", 32'(exp_b.last), 32'(got.last));
	endtask

	// result side: check each popped beat, then stall a random number of cycles
	always @(posedge clk) begin
		int stall;
		if (arst_n) begin
			if (pop && !empty) begin
				check_beat(out_item);
				if ($urandom_range(0, 31) == 0)
					rx_eager = !rx_eager;
				stall = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
				if (stall != 0) begin
					pop <= 1'b0;
					rx_wait <= stall - 1;
				end
			end else if (!pop) begin
				if (rx_wait == 0)
					pop <= 1'b1;
				else
					rx_wait <= rx_wait - 1;
			end
		end
	end

	// watchdog on cycles with no beat moving anywhere
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// push stays high across back-to-back beats so it never toggles in one step
	task automatic send_instr(input in_item_t it);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (full);
		predict_printout(it);
	endtask

	function automatic in_item_t print_instr(input logic [6:0] ch);
		in_item_t it;
		it.iot_bits    = OP_PRINT;
		it.accumulator = {5'($urandom_range(0, 31)), ch};
		return it;
	endfunction

	task automatic send_char(input logic [6:0] ch);
		send_instr(print_instr(ch));
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		col_limit = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t random_instr(input int eol_pct);
		in_item_t it;
		int       roll;
		logic [6:0] ch;
		it.accumulator = 12'($urandom_range(0, 4095));
		if ($urandom_range(0, 99) < 25) begin
			it.iot_bits = 3'($urandom_range(0, 3));
			return it;
		end
		it.iot_bits = OP_PRINT | 3'($urandom_range(0, 3));
		roll = $urandom_range(0, 99);
		if (roll < eol_pct) begin
			case ($urandom_range(0, 2))
				0: ch = CH_CR;
				1: ch = CH_LF;
				default: ch = CH_FF;
			endcase
		end else if (roll < eol_pct + 10) begin
			ch = CH_TAB;
		end else if (roll < eol_pct + 18) begin
			ch = 7'($urandom_range(0, 31));
		end else begin
			ch = 7'($urandom_range(32, 127));
		end
		it.accumulator[6:0] = ch;
		return it;
	endfunction

	// skip answers the ready flag as it was before clear and print
	task automatic test_iot_bits();
		send_instr('{iot_bits: OP_SKIP, accumulator: 12'hFFF});
		send_instr('{iot_bits: OP_CLEAR, accumulator: 12'h000});
		send_instr('{iot_bits: OP_SKIP, accumulator: 12'h5A5});
		send_instr('{iot_bits: OP_SKIP | OP_CLEAR, accumulator: 12'hA5A});
		send_instr('{iot_bits: OP_NONE, accumulator: 12'h123});
		send_instr('{iot_bits: OP_PRINT | OP_CLEAR, accumulator: 12'hE42});
		send_instr('{iot_bits: OP_SKIP, accumulator: 12'h000});
		send_instr('{iot_bits: OP_PRINT | OP_CLEAR | OP_SKIP, accumulator: 12'h843});
		send_instr('{iot_bits: OP_CLEAR, accumulator: 12'h000});
		send_instr('{iot_bits: OP_PRINT | OP_SKIP, accumulator: 12'h744});
		send_instr('{iot_bits: OP_PRINT, accumulator: 12'hF20});
	endtask

	task automatic test_char_classes();
		send_instr('{iot_bits: OP_PRINT, accumulator: {5'h1F, CH_CR}});
		send_char(CH_LF);
		send_char(CH_FF);
		send_char(CH_TAB);
		send_instr('{iot_bits: OP_PRINT, accumulator: 12'h000});
		send_char(7'h1F);
		send_instr('{iot_bits: OP_PRINT, accumulator: 12'hFFF});
		send_char(CH_SPACE);
		send_char(7'h7E);
	endtask

	task automatic test_tab_stops();
		send_char(CH_CR);
		send_char(CH_TAB);
		send_char(7'("x"));
		send_char(CH_TAB);
		repeat (6) send_char(7'("y"));
		send_char(CH_TAB);
	endtask

	// reset limit of 132, reached with tabs and then single characters
	task automatic test_reset_limit();
		send_char(CH_CR);
		repeat (16) send_char(CH_TAB);
		repeat (4) send_char(7'("z"));
	endtask

	task automatic test_limit_changes();
		write_limit(16'd1);
		send_char(7'("a"));
		send_char(CH_TAB);
		send_char(7'("b"));
		write_limit(16'd40);
		send_char(CH_CR);
		repeat (10) send_char(7'("c"));
		// lowered below the current column: next character wraps at once
		write_limit(16'd5);
		send_char(7'("d"));
		send_char(CH_TAB);
		send_char(7'("e"));
		write_limit(16'hFFFF);
		repeat (3) send_char(7'("f"));
		write_limit(16'd0);
		send_char(CH_CR);
		repeat (3) send_char(7'("g"));
	endtask

	task automatic test_random_traffic();
		logic [15:0] limits[7];
		limits = '{16'd132, 16'd8, 16'd1, 16'd40, 16'd0, 16'hFFFF, 16'd0};
		limits[6] = 16'($urandom_range(2, 200));
		foreach (limits[p]) begin
			write_limit(limits[p]);
			repeat (15) begin
				if ($urandom_range(0, 15) == 0)
					tx_eager = !tx_eager;
				send_instr(random_instr(limits[p] > 100 ? 1 : 6));
			end
		end
	endtask

	initial begin
		paper_col = '0;
		col_limit = COLUMN_LIMIT_RST;
		printer_ready = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_iot_bits();
		test_char_classes();
		test_tab_stops();
		test_reset_limit();
		test_limit_changes();
		test_random_traffic();
		wait_drained();
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
